### sv/bsd_pkg.sv
package bsd_pkg;

    localparam int unsigned OP_COUNT  = 46;
    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_TRUNC   = 2'd2
    } status_t;

    typedef enum logic {
        KIND_INSN    = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef struct packed {
        logic [3:0] len;
        logic [1:0] pops;
        logic [1:0] pushes;
        logic [3:0] imm_bytes;
        logic       term;
        logic       sx32;
        logic       two;
    } op_info_t;

    typedef struct packed {
        kind_t       kind;
        logic [5:0]  opcode;
        logic [63:0] operand_first;
        logic [7:0]  operand_second;
        logic [3:0]  insn_length;
        logic [15:0] insn_offset;
        logic [15:0] max_depth;
        status_t     status;
        logic        last;
    } result_t;

    // Results produced by one byte: up to an instruction and a summary.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic op_info_t op_info(input logic [5:0] op);
        op_info_t info;
        info = '{len: 4'd1, pops: 2'd0, pushes: 2'd0, imm_bytes: 4'd0,
                 term: 1'b0, sx32: 1'b0, two: 1'b0};
        unique case (op) inside
            6'd0, 6'd44:
                info.len = 4'd1;
            6'd1:
                info.term = 1'b1;
            6'd2, 6'd3:
            begin
                info.len = 4'd9; info.pushes = 2'd1; info.imm_bytes = 4'd8;
            end
            6'd4, 6'd5, 6'd6, 6'd8, 6'd26, 6'd30:
            begin
                info.len = 4'd3; info.pushes = 2'd1; info.imm_bytes = 4'd2;
            end
            6'd7, 6'd9:
            begin
                info.len = 4'd3; info.pops = 2'd1; info.imm_bytes = 4'd2;
            end
            6'd10:
            begin
                info.len = 4'd3; info.imm_bytes = 4'd2;
            end
            6'd11:
            begin
                info.pops = 2'd1; info.pushes = 2'd2;
            end
            6'd12:
            begin
                info.pops = 2'd2; info.pushes = 2'd2;
            end
            [6'd13:6'd17], [6'd20:6'd25], 6'd27, 6'd28, 6'd31, 6'd41:
            begin
                info.pops = 2'd2; info.pushes = 2'd1;
            end
            6'd18, 6'd19, 6'd40:
            begin
                info.pops = 2'd1; info.pushes = 2'd1;
            end
            6'd29, 6'd32:
            begin
                info.pops = 2'd3; info.pushes = 2'd1;
            end
            6'd33, 6'd43:
            begin
                info.len = 4'd5; info.imm_bytes = 4'd4; info.sx32 = 1'b1;
            end
            6'd34, 6'd35:
            begin
                info.len = 4'd5; info.pops = 2'd1; info.imm_bytes = 4'd4;
                info.sx32 = 1'b1;
            end
            6'd36:
            begin
                info.len = 4'd3; info.imm_bytes = 4'd1; info.two = 1'b1;
            end
            6'd37:
            begin
                info.len = 4'd2; info.imm_bytes = 4'd1; info.term = 1'b1;
            end
            6'd38:
            begin
                info.len = 4'd4; info.pushes = 2'd1; info.imm_bytes = 4'd2;
                info.two = 1'b1;
            end
            6'd39:
            begin
                info.len = 4'd3; info.pops = 2'd1; info.pushes = 2'd1;
                info.imm_bytes = 4'd2;
            end
            6'd42:
            begin
                info.pops = 2'd1; info.term = 1'b1;
            end
            6'd45:
                info.pops = 2'd1;
            default:
                info.len = 4'd1;
        endcase
        return info;
    endfunction

endpackage

### sv/bsd_if.sv
interface bsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       is_last;

    modport source (output valid, output code_byte, output is_last, input ready);
    modport sink   (input valid, input code_byte, input is_last, output ready);
endinterface

interface bsd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [5:0]  opcode;
    logic [63:0] operand_first;
    logic [7:0]  operand_second;
    logic [3:0]  insn_length;
    logic [15:0] insn_offset;
    logic [15:0] max_depth;
    logic [1:0]  status;
    logic        last;

    modport source (
        output valid, output result_kind, output opcode, output operand_first,
        output operand_second, output insn_length, output insn_offset,
        output max_depth, output status, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input opcode, input operand_first,
        input operand_second, input insn_length, input insn_offset,
        input max_depth, input status, input last, output ready
    );
endinterface

### sv/bytecode_stream_decoder.sv
// Throughput: one byte per cycle while the result queue has room; a byte that both
// completes an instruction and ends the block yields two results, which the single
// output port drains one at a time.
// The four-entry result queue sets how far input can run ahead of a stalled output.
// Reset (rst_n, asynchronous, active low) clears all decode state, so the next
// byte starts a block at offset zero with depth and status cleared.
module bytecode_stream_decoder (
    input logic      clk,
    input logic      rst_n,
    bsd_in_if.sink   in_ch,
    bsd_out_if.source out_ch
);
    import bsd_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       room;
    logic       advance;
    push_t      push;
    result_t    out_data;

    assign advance     = in_valid_reg && room;
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            byte_reg <= in_ch.code_byte;
            last_reg <= in_ch.is_last;
        end
    end

    bsd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .code_byte (byte_reg),
        .is_last   (last_reg),
        .push      (push)
    );

    bsd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .room      (room),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.result_kind    = out_data.kind;
    assign out_ch.opcode         = out_data.opcode;
    assign out_ch.operand_first  = out_data.operand_first;
    assign out_ch.operand_second = out_data.operand_second;
    assign out_ch.insn_length    = out_data.insn_length;
    assign out_ch.insn_offset    = out_data.insn_offset;
    assign out_ch.max_depth      = out_data.max_depth;
    assign out_ch.status         = out_data.status;
    assign out_ch.last           = out_data.last;

endmodule

### sv/bsd_decode.sv
module bsd_decode (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic [7:0]     code_byte,
    input  logic           is_last,
    output bsd_pkg::push_t push
);
    import bsd_pkg::*;

    logic [3:0]  rem_reg, rem_next;
    logic [5:0]  op_reg, op_next;
    logic [63:0] shift_reg, shift_next;
    logic [7:0]  second_reg, second_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] depth_reg, depth_next;
    logic [15:0] peak_reg, peak_next;
    status_t     err_reg, err_next;

    op_info_t    info_cur;
    op_info_t    info_new;
    op_info_t    info_fin;
    logic [2:0]  pos;
    logic        done;
    logic [15:0] depth_sub;
    logic [16:0] depth_sum;
    logic [15:0] depth_sat;
    logic [63:0] operand;
    status_t     err_fin;
    result_t     insn_res;
    result_t     sum_res;

    always_comb
    begin
        rem_next    = rem_reg;
        op_next     = op_reg;
        shift_next  = shift_reg;
        second_next = second_reg;
        start_next  = start_reg;
        depth_next  = depth_reg;
        peak_next   = peak_reg;
        err_next    = err_reg;
        done        = 1'b0;
        info_cur    = op_info(op_reg);
        info_new    = op_info(code_byte[5:0]);
        pos         = 3'(info_cur.len - 4'd1 - rem_reg);

        if (err_reg == STATUS_OK)
        begin
            if (rem_reg == 4'd0)
            begin
                if (code_byte >= 8'(OP_COUNT))
                begin
                    err_next = STATUS_UNKNOWN;
                end
                else
                begin
                    op_next     = code_byte[5:0];
                    start_next  = offset_reg;
                    rem_next    = info_new.len - 4'd1;
                    shift_next  = '0;
                    second_next = '0;
                    done        = (info_new.len == 4'd1);
                end
            end
            else
            begin
                if ({1'b0, pos} < info_cur.imm_bytes)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (pos == 3'(i))
                        begin
                            shift_next[8*i +: 8] = code_byte;
                        end
                    end
                end
                else
                begin
                    second_next = code_byte;
                end
                rem_next = rem_reg - 4'd1;
                done     = (rem_reg == 4'd1);
            end
        end

        // Stack estimate for the completed instruction.
        info_fin  = op_info(op_next);
        depth_sub = (depth_reg >= 16'(info_fin.pops)) ?
                    depth_reg - 16'(info_fin.pops) : 16'd0;
        depth_sum = {1'b0, depth_sub} + 17'(info_fin.pushes);
        depth_sat = depth_sum[16] ? DEPTH_MAX : depth_sum[15:0];
        if (done)
        begin
            depth_next = info_fin.term ? 16'd0 : depth_sat;
            peak_next  = (depth_sat > peak_reg) ? depth_sat : peak_reg;
        end

        operand = shift_next;
        if (info_fin.sx32 && operand[31])
        begin
            operand[63:32] = '1;
        end

        insn_res.kind           = KIND_INSN;
        insn_res.opcode         = op_next;
        insn_res.operand_first  = operand;
        insn_res.operand_second = info_fin.two ? second_next : 8'd0;
        insn_res.insn_length    = info_fin.len;
        insn_res.insn_offset    = start_next;
        insn_res.max_depth      = peak_next;
        insn_res.status         = STATUS_OK;
        insn_res.last           = !is_last;

        err_fin = err_next;
        if (err_next == STATUS_OK && rem_next != 4'd0)
        begin
            err_fin = STATUS_TRUNC;
        end

        sum_res.kind           = KIND_SUMMARY;
        sum_res.opcode         = '0;
        sum_res.operand_first  = '0;
        sum_res.operand_second = '0;
        sum_res.insn_length    = '0;
        sum_res.insn_offset    = '0;
        sum_res.max_depth      = peak_next;
        sum_res.status         = err_fin;
        sum_res.last           = 1'b1;

        offset_next = offset_reg + 16'd1;

        // The end of a block returns everything to its reset state.
        if (is_last)
        begin
            rem_next    = '0;
            op_next     = '0;
            shift_next  = '0;
            second_next = '0;
            start_next  = '0;
            depth_next  = '0;
            peak_next   = '0;
            err_next    = STATUS_OK;
            offset_next = '0;
        end

        push.count  = 2'(done) + 2'(is_last);
        push.first  = done ? insn_res : sum_res;
        push.second = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            op_reg     <= '0;
            shift_reg  <= '0;
            second_reg <= '0;
            offset_reg <= '0;
            start_reg  <= '0;
            depth_reg  <= '0;
            peak_reg   <= '0;
            err_reg    <= STATUS_OK;
        end
        else if (advance)
        begin
            rem_reg    <= rem_next;
            op_reg     <= op_next;
            shift_reg  <= shift_next;
            second_reg <= second_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            depth_reg  <= depth_next;
            peak_reg   <= peak_next;
            err_reg    <= err_next;
        end
    end

endmodule

### sv/bsd_result_queue.sv
module bsd_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_en,
    input  bsd_pkg::push_t   push,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output bsd_pkg::result_t out_data
);
    import bsd_pkg::*;

    result_t    entry_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic [1:0] n_push;
    logic       pop;

    assign room      = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign out_data  = entry_reg[head_reg];

    always_comb
    begin
        n_push     = push_en ? push.count : 2'd0;
        pop        = out_valid && out_ready;
        head_next  = head_reg + 2'(pop);
        tail_next  = tail_reg + n_push;
        count_next = count_reg + 3'(n_push) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[tail_reg] <= push.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[tail_reg + 2'd1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bsd_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 16;
    localparam int RANDOM_BYTES = 1000;
    localparam int DUP_RUN      = 200;

    // Opcodes that the directed part and the long block name.
    localparam logic [7:0] OPC_NOP      = 8'd0;
    localparam logic [7:0] OPC_HALT     = 8'd1;
    localparam logic [7:0] OPC_PUSH_F64 = 8'd3;
    localparam logic [7:0] OPC_PUSH_U16 = 8'd4;
    localparam logic [7:0] OPC_DUP      = 8'd11;
    localparam logic [7:0] OPC_JUMP     = 8'd33;
    localparam logic [7:0] OPC_CLOSURE  = 8'd38;
    localparam logic [7:0] OPC_DROP     = 8'd45;

    localparam logic [3:0] F_TERM = 4'h1;
    localparam logic [3:0] F_SX32 = 4'h2;
    localparam logic [3:0] F_TWO  = 4'h4;

    // One hex digit each: length, pops, pushes, first-immediate bytes, flags.
    typedef struct packed {
        logic [3:0] len;
        logic [3:0] pops;
        logic [3:0] pushes;
        logic [3:0] imm;
        logic [3:0] flags;
    } shape_t;

    localparam shape_t OP_SHAPE [46] = '{
        20'h10000, 20'h10001, 20'h90180, 20'h90180, 20'h30120, 20'h30120,
        20'h30120, 20'h31020, 20'h30120, 20'h31020, 20'h30020, 20'h11200,
        20'h12200, 20'h12100, 20'h12100, 20'h12100, 20'h12100, 20'h12100,
        20'h11100, 20'h11100, 20'h12100, 20'h12100, 20'h12100, 20'h12100,
        20'h12100, 20'h12100, 20'h30120, 20'h12100, 20'h12100, 20'h13100,
        20'h30120, 20'h12100, 20'h13100, 20'h50042, 20'h51042, 20'h51042,
        20'h30014, 20'h20011, 20'h40124, 20'h31120, 20'h11100, 20'h12100,
        20'h11001, 20'h50042, 20'h10000, 20'h11000
    };

    typedef struct packed {
        logic [7:0] code;
        logic       fin;
        logic       has_want;
        result_t    want;
    } step_t;

    logic clk = 1'b0;
    logic rst_n;

    bsd_in_if  in_ch ();
    bsd_out_if out_ch ();

    bytecode_stream_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decoder state as the stream has left it.
    logic [3:0]  ops_left;
    logic [5:0]  cur_op;
    logic [63:0] imm_acc;
    logic [7:0]  imm_second;
    logic [15:0] byte_pos;
    logic [15:0] insn_base;
    logic [15:0] depth;
    logic [15:0] depth_peak;
    status_t     block_status;

    result_t     pending_results [$];
    logic [7:0]  block_bytes [$];

    int          mismatches = 0;
    int          requests_sent = 0;
    int          insns_seen = 0;
    int          ends_seen [3] = '{0, 0, 0};
    logic [63:0] opcodes_hit = '0;
    logic [15:0] deepest_seen = '0;
    int          burst_left = 0;
    int          gap;
    logic [15:0] stall_mask = 16'hFFFF;
    int          stall_age = 0;

    function automatic void clear_state();
        ops_left     = '0;
        cur_op       = '0;
        imm_acc      = '0;
        imm_second   = '0;
        byte_pos     = '0;
        insn_base    = '0;
        depth        = '0;
        depth_peak   = '0;
        block_status = STATUS_OK;
    endfunction

    function automatic result_t block_end(input logic [15:0] peak, input status_t st);
        return '{KIND_SUMMARY, 6'd0, 64'd0, 8'd0, 4'd0, 16'd0, peak, st, 1'b1};
    endfunction

    function automatic result_t retire_insn();
        shape_t      shape;
        logic [16:0] d;
        logic [63:0] v;
        shape = OP_SHAPE[cur_op];
        d = (depth >= shape.pops) ? {1'b0, depth} - {13'd0, shape.pops} : 17'd0;
        d = d + {13'd0, shape.pushes};
        if (d > {1'b0, DEPTH_MAX})
            d = {1'b0, DEPTH_MAX};
        depth = d[15:0];
        if (depth > depth_peak)
            depth_peak = depth;
        if ((shape.flags & F_TERM) != 0)
            depth = '0;
        v = imm_acc;
        if ((shape.flags & F_SX32) != 0 && v[31])
            v[63:32] = '1;
        return '{KIND_INSN, cur_op, v, ((shape.flags & F_TWO) != 0) ? imm_second : 8'd0,
                 shape.len, insn_base, depth_peak, STATUS_OK, 1'b0};
    endfunction

    // Advances the decoder by one byte and queues the results it causes.
    function automatic void decode_byte(input logic [7:0] code, input logic fin);
        result_t    outs [2];
        int         n;
        shape_t     shape;
        logic [3:0] pos;
        n = 0;
        if (block_status == STATUS_OK)
        begin
            if (ops_left == 0)
            begin
                if (code >= OP_COUNT)
                    block_status = STATUS_UNKNOWN;
                else
                begin
                    cur_op     = code[5:0];
                    insn_base  = byte_pos;
                    ops_left   = OP_SHAPE[code[5:0]].len - 4'd1;
                    imm_acc    = '0;
                    imm_second = '0;
                    if (ops_left == 0)
                    begin
                        outs[n] = retire_insn();
                        n++;
                    end
                end
            end
            else
            begin
                shape = OP_SHAPE[cur_op];
                pos = shape.len - 4'd1 - ops_left;
                if (pos < shape.imm)
                    imm_acc = imm_acc | ({56'd0, code} << (8 * pos));
                else
                    imm_second = code;
                ops_left--;
                if (ops_left == 0)
                begin
                    outs[n] = retire_insn();
                    n++;
                end
            end
        end
        byte_pos++;
        if (fin)
        begin
            if (block_status == STATUS_OK && ops_left != 0)
                block_status = STATUS_TRUNC;
            outs[n] = block_end(depth_peak, block_status);
            n++;
            clear_state();
        end
        for (int i = 0; i < n; i++)
        begin
            outs[i].last = (i == n - 1);
            pending_results.push_back(outs[i]);
        end
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("kind %0d op %0d a %h b %h len %0d off %0d max %0d st %0d last %0d",
                         r.kind, r.opcode, r.operand_first, r.operand_second, r.insn_length,
                         r.insn_offset, r.max_depth, r.status, r.last);
    endfunction

    task automatic check_result();
        result_t got;
        result_t want;
        got.kind           = kind_t'(out_ch.result_kind);
        got.opcode         = out_ch.opcode;
        got.operand_first  = out_ch.operand_first;
        got.operand_second = out_ch.operand_second;
        got.insn_length    = out_ch.insn_length;
        got.insn_offset    = out_ch.insn_offset;
        got.max_depth      = out_ch.max_depth;
        got.status         = status_t'(out_ch.status);
        got.last           = out_ch.last;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: %s", show(got));
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.opcode !== want.opcode ||
                got.operand_first !== want.operand_first ||
                got.operand_second !== want.operand_second ||
                got.insn_length !== want.insn_length || got.insn_offset !== want.insn_offset ||
                got.max_depth !== want.max_depth || got.status !== want.status ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
            end
        end
        if (got.kind == KIND_INSN)
        begin
            insns_seen++;
            opcodes_hit[got.opcode] = 1'b1;
        end
        else if (got.status <= STATUS_TRUNC)
            ends_seen[got.status]++;
        if (got.max_depth > deepest_seen)
            deepest_seen = got.max_depth;
    endtask

    always @(negedge clk)
    begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            check_result();
    end

    // The receiver stalls on a rotating mask that is redrawn at random whenever its age counter runs out.
    always @(posedge clk)
    begin
        if (stall_age == 0)
        begin
            stall_age = 64;
            if ($urandom_range(0, 3) == 0)
                stall_mask = 16'hFFFF;
            else
                stall_mask = 16'($urandom) | 16'h0001;
        end
        stall_age--;
        stall_mask = {stall_mask[14:0], stall_mask[15]};
        out_ch.ready <= stall_mask[0];
    end

    task automatic send_byte(input logic [7:0] code, input logic fin,
                             input logic has_want, input result_t want);
        logic taken;
        in_ch.valid     <= 1'b1;
        in_ch.code_byte <= code;
        in_ch.is_last   <= fin;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = (in_ch.ready === 1'b1);
            if (taken)
            begin
                decode_byte(code, fin);
                if (has_want)
                    pending_results[pending_results.size() - 1] = want;
                requests_sent++;
            end
            @(posedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Appends an instruction, cut to its first keep bytes.
    function automatic void add_insn(input logic [5:0] op, input int keep);
        block_bytes.push_back({2'b00, op});
        for (int i = 1; i < keep; i++)
        begin
            case ($urandom_range(0, 7))
                0: block_bytes.push_back(8'h00);
                1: block_bytes.push_back(8'hFF);
                2: block_bytes.push_back(8'h80);
                3: block_bytes.push_back(8'h7F);
                default: block_bytes.push_back(8'($urandom));
            endcase
        end
    endfunction

    task automatic run_block(output int sent);
        int         pick;
        logic [5:0] op;
        pick = $urandom_range(0, 99);
        block_bytes.delete();
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 20))
                block_bytes.push_back(8'($urandom));
        end
        else
        begin
            repeat ((pick < 65) ? $urandom_range(1, 12) : $urandom_range(0, 6))
            begin
                op = 6'($urandom_range(0, OP_COUNT - 1));
                add_insn(op, OP_SHAPE[op].len);
            end
            if (pick >= 65 && pick < 80)
            begin
                do
                    op = 6'($urandom_range(0, OP_COUNT - 1));
                while (OP_SHAPE[op].len == 1);
                add_insn(op, $urandom_range(1, OP_SHAPE[op].len - 1));
            end
            else if (pick >= 80)
            begin
                block_bytes.push_back(8'($urandom_range(OP_COUNT, 255)));
                repeat ($urandom_range(0, 4))
                    block_bytes.push_back(8'($urandom));
            end
        end
        foreach (block_bytes[i])
            send_byte(block_bytes[i], i == block_bytes.size() - 1, 1'b0, '0);
        sent = block_bytes.size();
    endtask

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_results.size());
        $display("tb: failure");
        $finish;
    end

    initial
    begin : stimulus
        step_t steps [25];
        int    random_bytes;
        int    sent;
        logic  long_done;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.code_byte <= 8'h00;
        in_ch.is_last   <= 1'b0;
        clear_state();

        // A clean block with wide, signed and two-operand immediates, a block
        // that hits an unknown opcode, and one that ends inside an instruction.
        steps = '{
            '{OPC_NOP, 1'b0, 1'b1, '{KIND_INSN, OPC_NOP[5:0], 64'd0, 8'd0, 4'd1, 16'd0,
                                     16'd0, STATUS_OK, 1'b1}},
            '{OPC_PUSH_F64, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, '0},
            '{OPC_JUMP, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
            '{8'h00, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
            '{OPC_CLOSURE, 1'b0, 1'b0, '0},
            '{8'h34, 1'b0, 1'b0, '0}, '{8'h12, 1'b0, 1'b0, '0}, '{8'hAB, 1'b0, 1'b0, '0},
            '{OPC_HALT, 1'b0, 1'b0, '0},
            '{OPC_DROP, 1'b1, 1'b1, block_end(16'd2, STATUS_OK)},
            '{8'(OP_COUNT), 1'b0, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b1, block_end(16'd0, STATUS_UNKNOWN)},
            '{OPC_PUSH_U16, 1'b0, 1'b0, '0},
            '{8'h12, 1'b1, 1'b1, block_end(16'd0, STATUS_TRUNC)}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send_byte(steps[i].code, steps[i].fin, steps[i].has_want, steps[i].want);
        drain_results();

        random_bytes = 0;
        long_done = 1'b0;
        while (random_bytes < RANDOM_BYTES)
        begin
            run_block(sent);
            random_bytes += sent;
            if (!long_done && random_bytes >= RANDOM_BYTES / 2)
            begin
                // A long run of pushes builds a deep stack before a halt clears it.
                long_done = 1'b1;
                drain_results();
                repeat (DUP_RUN)
                    send_byte(OPC_DUP, 1'b0, 1'b0, '0);
                send_byte(OPC_HALT, 1'b0, 1'b0, '0);
                send_byte(OPC_NOP, 1'b1, 1'b0, '0);
            end
        end

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d instructions over %0d of %0d opcodes, peak depth %0d",
                 requests_sent, insns_seen, $countones(opcodes_hit), OP_COUNT, deepest_seen);
        $display("blocks ended ok %0d, unknown opcode %0d, truncated %0d; %0d mismatches",
                 ends_seen[0], ends_seen[1], ends_seen[2], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### files.f
sv/bsd_pkg.sv
sv/bsd_if.sv
sv/bsd_decode.sv
sv/bsd_result_queue.sv
sv/bytecode_stream_decoder.sv
test/testbench.sv
